### hw/rtl/riot_mbx_pkg.sv
// ----------------------------------------------------------------------------
// riot_mbx_pkg
// Shared types and constants for the RIOT mailbox with command FIFO.
// ----------------------------------------------------------------------------
package riot_mbx_pkg;

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [3:0] {
    KIND_RIOT_READ  = 4'd0,
    KIND_RIOT_WRITE = 4'd1,
    KIND_TICK       = 4'd2,
    KIND_POP        = 4'd3,
    KIND_RESPOND    = 4'd4,
    KIND_MAIN_READ  = 4'd5,
    KIND_READY_READ = 4'd6,
    KIND_PUSH       = 4'd7,
    KIND_RESET      = 4'd8
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  localparam logic [4:0] OFS_PORT_A = 5'h00;
  localparam logic [4:0] OFS_DDR_A  = 5'h01;
  localparam logic [4:0] OFS_PORT_B = 5'h02;
  localparam logic [4:0] OFS_DDR_B  = 5'h03;
  localparam logic [4:0] OFS_FLAG   = 5'h05;
  localparam logic [4:0] OFS_TIMER  = 5'h1f;

  localparam logic [7:0] PA_READ_MASK = 8'h7f;
  localparam logic [7:0] PA_FORCE_BIT = 8'h10;
  localparam logic [7:0] BIT_7        = 8'h80;
  localparam logic [7:0] BIT_6        = 8'h40;
  localparam logic [7:0] CLR_BIT_6    = 8'hbf;
  localparam logic [7:0] CLR_BITS_76  = 8'h3f;

endpackage

### hw/rtl/riot_mailbox_fifo.sv
// ----------------------------------------------------------------------------
// riot_mailbox_fifo
// Simplified 6532 RIOT with a command FIFO and response mailbox.
// ----------------------------------------------------------------------------
// Each request passes through two states: acceptance in ST_IDLE reads the
// head of the command memory, and ST_EXEC updates the registers, writes the
// memory on a push and loads the output register. ST_EXEC waits while the
// output register still holds a response that has not been taken, and no
// new request is accepted until the current one has left ST_EXEC.
module riot_mailbox_fifo
  import riot_mbx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // offset[4:0], data[12:5], zero[15:13]
  input  logic [3:0]  s_tuser,   // kind[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // read_data[7:0], irq[8], zero[15:9]
);

  state_t state, state_next;

  logic [7:0] cmd_mem [FIFO_DEPTH];
  logic [7:0] head_q;

  kind_t      kind;
  logic [4:0] offset;
  logic [7:0] data;

  logic [PTR_W-1:0] read_pointer, read_pointer_next;
  logic [PTR_W-1:0] write_pointer, write_pointer_next;
  logic [CNT_W-1:0] command_count, command_count_next;
  logic [7:0] response_byte, response_byte_next;
  logic [7:0] port_a_latch, port_a_latch_next;
  logic [7:0] port_b_latch, port_b_latch_next;
  logic [7:0] direction_a, direction_a_next;
  logic [7:0] direction_b, direction_b_next;
  logic [7:0] countdown, countdown_next;
  logic       countdown_active, countdown_active_next;
  logic       timer_flag, timer_flag_next;

  logic [7:0] rd_value;
  logic       irq_value;
  logic       mem_we;
  logic [PTR_W-1:0] mem_waddr;

  logic       in_fire;
  logic       exec_done;
  logic       fifo_full;
  logic       fifo_empty;
  logic [7:0] tick_value;

  logic [7:0] out_read_data;
  logic       out_irq;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign fifo_full  = (command_count == CNT_W'(FIFO_DEPTH));
  assign fifo_empty = (command_count == '0);
  assign in_fire    = s_tvalid && s_tready;
  assign tick_value = countdown - 8'd1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
      ST_EXEC: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready  = 1'b0;
    exec_done = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_EXEC: exec_done = !m_tvalid || m_tready;
      default: begin
        s_tready  = 1'b0;
        exec_done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind   <= kind_t'(s_tuser);
      offset <= s_tdata[4:0];
      data   <= s_tdata[12:5];
    end
  end

  // command memory
  always_ff @(posedge clk) begin
    if (in_fire) begin
      head_q <= cmd_mem[read_pointer];
    end
    if (mem_we) begin
      cmd_mem[mem_waddr] <= data;
    end
  end

  // execute
  always_comb begin
    read_pointer_next     = read_pointer;
    write_pointer_next    = write_pointer;
    command_count_next    = command_count;
    response_byte_next    = response_byte;
    port_a_latch_next     = port_a_latch;
    port_b_latch_next     = port_b_latch;
    direction_a_next      = direction_a;
    direction_b_next      = direction_b;
    countdown_next        = countdown;
    countdown_active_next = countdown_active;
    timer_flag_next       = timer_flag;
    rd_value              = 8'h00;
    irq_value             = 1'b0;
    mem_we                = 1'b0;
    mem_waddr             = write_pointer;
    case (kind)
      KIND_RIOT_READ: begin
        case (offset)
          OFS_PORT_A: rd_value = (port_a_latch & PA_READ_MASK) | PA_FORCE_BIT
                                 | (fifo_empty ? 8'h00 : BIT_7);
          OFS_DDR_A:  rd_value = direction_a;
          OFS_PORT_B: rd_value = port_b_latch;
          OFS_DDR_B:  rd_value = direction_b;
          OFS_FLAG: begin
            rd_value        = timer_flag ? BIT_7 : 8'h00;
            timer_flag_next = 1'b0;
          end
          default: rd_value = 8'h00;
        endcase
      end
      KIND_RIOT_WRITE: begin
        case (offset)
          OFS_PORT_A: port_a_latch_next = (port_a_latch & ~direction_a)
                                          | (data & direction_a);
          OFS_DDR_A:  direction_a_next = data;
          OFS_PORT_B: port_b_latch_next = data;
          OFS_DDR_B:  direction_b_next = data;
          OFS_TIMER: begin
            countdown_next        = {1'b0, data[7:1]};
            countdown_active_next = 1'b1;
          end
          default: ;
        endcase
      end
      KIND_TICK: begin
        if (countdown_active) begin
          countdown_next = tick_value;
          if (tick_value == 8'h00) begin
            countdown_active_next = 1'b0;
            timer_flag_next       = 1'b1;
            irq_value             = 1'b1;
          end
        end
      end
      KIND_POP: begin
        rd_value = head_q;
        if (!fifo_empty) begin
          command_count_next = command_count - 1'b1;
          read_pointer_next  = next_slot(read_pointer);
        end
      end
      KIND_RESPOND: begin
        response_byte_next = data;
        port_a_latch_next  = port_a_latch | BIT_6;
      end
      KIND_MAIN_READ: begin
        port_a_latch_next = port_a_latch & CLR_BIT_6;
        rd_value          = response_byte;
      end
      KIND_READY_READ: begin
        rd_value = (port_a_latch & BIT_6) | (fifo_full ? BIT_7 : 8'h00);
      end
      KIND_PUSH: begin
        mem_we = 1'b1;
        if (fifo_full) begin
          mem_waddr          = read_pointer;
          command_count_next = CNT_W'(1);
          write_pointer_next = next_slot(read_pointer);
        end else begin
          mem_waddr          = write_pointer;
          write_pointer_next = next_slot(write_pointer);
          command_count_next = command_count + 1'b1;
        end
      end
      KIND_RESET: begin
        response_byte_next = 8'h00;
        read_pointer_next  = '0;
        write_pointer_next = '0;
        command_count_next = '0;
        port_a_latch_next  = port_a_latch & CLR_BITS_76;
      end
      default: ;
    endcase
    mem_we = mem_we && exec_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer     <= '0;
      write_pointer    <= '0;
      command_count    <= '0;
      response_byte    <= 8'h00;
      port_a_latch     <= 8'h00;
      port_b_latch     <= 8'h00;
      direction_a      <= 8'h00;
      direction_b      <= 8'h00;
      countdown        <= 8'h00;
      countdown_active <= 1'b0;
      timer_flag       <= 1'b0;
    end else if (exec_done) begin
      read_pointer     <= read_pointer_next;
      write_pointer    <= write_pointer_next;
      command_count    <= command_count_next;
      response_byte    <= response_byte_next;
      port_a_latch     <= port_a_latch_next;
      port_b_latch     <= port_b_latch_next;
      direction_a      <= direction_a_next;
      direction_b      <= direction_b_next;
      countdown        <= countdown_next;
      countdown_active <= countdown_active_next;
      timer_flag       <= timer_flag_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      out_read_data <= rd_value;
      out_irq       <= irq_value;
    end
  end

  assign m_tdata = {7'd0, out_irq, out_read_data};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    command_count <= CNT_W'(FIFO_DEPTH))
    else $error("command count above FIFO depth");

  a_valid_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_EXEC))
    else $error("response raised without execute cycle");

  a_expire_sets_flag: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(countdown_active) |-> timer_flag)
    else $error("countdown stopped without setting timer flag");

  a_no_accept_in_exec: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ST_EXEC && !s_tready)
    else $error("request accepted while another is executing");
`endif

endmodule

### test/riot_mailbox_fifo_test.sv
// ----------------------------------------------------------------------------
// riot_mailbox_fifo_test
// Self-checking bench for the RIOT mailbox. A short directed table covers
// reset values, port masking, the timer, flags and the command FIFO, then
// random request sequences run against a cycle-free model of the mailbox.
// ----------------------------------------------------------------------------
module riot_mailbox_fifo_test;
  import riot_mbx_pkg::*;

  localparam logic [3:0] KIND_UNUSED_TOP = 4'hf;
  localparam int         RANDOM_REQUESTS = 1100;
  localparam int         QUIET_LIMIT     = 2000;
  localparam int         HOLD_START      = 800;
  localparam int         HOLD_CYCLES     = 300;
  localparam int         CALM_START      = 1500;
  localparam int         CALM_CYCLES     = 600;

  typedef struct packed {
    logic [7:0] rd;
    logic       irq;
  } reply_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [4:0] ofs;
    logic [7:0] dat;
    bit         typed;
    reply_t     reply;
  } dir_row_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic [3:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  riot_mailbox_fifo u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // mailbox state as the model sees it
  logic [7:0]            cmd_mem [FIFO_DEPTH];
  bit   [FIFO_DEPTH-1:0] cmd_written = '0;
  logic [PTR_W-1:0]      rd_ptr    = '0;
  logic [PTR_W-1:0]      wr_ptr    = '0;
  logic [CNT_W-1:0]      cmd_cnt   = '0;
  logic [7:0]            resp_byte = '0;
  logic [7:0]            pa        = '0;
  logic [7:0]            pb        = '0;
  logic [7:0]            ddra      = '0;
  logic [7:0]            ddrb      = '0;
  logic [7:0]            tmr_cnt   = '0;
  bit                    tmr_run   = 1'b0;
  bit                    tmr_flag  = 1'b0;

  reply_t pending_replies [$];
  int     mismatches    = 0;
  int     requests_sent = 0;
  bit     send_calm     = 1'b0;
  bit     wrap_done     = 1'b0;

  dir_row_t dir_rows [27] = '{
    '{KIND_RIOT_READ,  OFS_PORT_A, 8'h00, 1'b1, '{8'h10, 1'b0}},
    '{KIND_RIOT_READ,  OFS_FLAG,   8'h00, 1'b1, '{8'h00, 1'b0}},
    '{KIND_READY_READ, OFS_PORT_A, 8'h00, 1'b1, '{8'h00, 1'b0}},
    '{KIND_MAIN_READ,  OFS_PORT_A, 8'h00, 1'b1, '{8'h00, 1'b0}},
    '{KIND_RIOT_WRITE, OFS_DDR_A,  8'hff, 1'b1, '{8'h00, 1'b0}},
    '{KIND_RIOT_WRITE, OFS_PORT_A, 8'hff, 1'b1, '{8'h00, 1'b0}},
    '{KIND_RIOT_READ,  OFS_PORT_A, 8'h00, 1'b1, '{8'h7f, 1'b0}},
    '{KIND_RIOT_WRITE, OFS_DDR_A,  8'h0f, 1'b0, '{8'h00, 1'b0}},
    '{KIND_RIOT_WRITE, OFS_PORT_A, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{KIND_RIOT_READ,  OFS_PORT_A, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{KIND_RIOT_WRITE, OFS_PORT_B, 8'ha5, 1'b0, '{8'h00, 1'b0}},
    '{KIND_RIOT_READ,  OFS_PORT_B, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{KIND_RIOT_WRITE, OFS_TIMER,  8'h03, 1'b1, '{8'h00, 1'b0}},
    '{KIND_TICK,       OFS_PORT_A, 8'h00, 1'b1, '{8'h00, 1'b1}},
    '{KIND_RIOT_READ,  OFS_FLAG,   8'h00, 1'b1, '{8'h80, 1'b0}},
    '{KIND_RIOT_READ,  OFS_FLAG,   8'h00, 1'b1, '{8'h00, 1'b0}},
    '{KIND_RESPOND,    OFS_PORT_A, 8'hff, 1'b1, '{8'h00, 1'b0}},
    '{KIND_READY_READ, OFS_PORT_A, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{KIND_MAIN_READ,  OFS_PORT_A, 8'h00, 1'b1, '{8'hff, 1'b0}},
    '{KIND_PUSH,       OFS_PORT_A, 8'hff, 1'b1, '{8'h00, 1'b0}},
    '{KIND_PUSH,       OFS_PORT_A, 8'h00, 1'b1, '{8'h00, 1'b0}},
    '{KIND_POP,        OFS_PORT_A, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{KIND_POP,        OFS_PORT_A, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{KIND_RESET,      OFS_PORT_A, 8'h00, 1'b1, '{8'h00, 1'b0}},
    '{KIND_POP,        OFS_PORT_A, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{KIND_RIOT_READ,  OFS_TIMER,  8'h00, 1'b1, '{8'h00, 1'b0}},
    '{KIND_UNUSED_TOP, OFS_TIMER,  8'hff, 1'b1, '{8'h00, 1'b0}}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [PTR_W-1:0] slot_after(logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic reply_t mailbox_predict(logic [3:0] kind, logic [4:0] ofs,
                                             logic [7:0] dat);
    reply_t r;
    r = '0;
    case (kind)
      KIND_RIOT_READ: begin
        case (ofs)
          OFS_PORT_A: r.rd = (pa & PA_READ_MASK) | PA_FORCE_BIT |
                             ((cmd_cnt != 0) ? BIT_7 : 8'h00);
          OFS_DDR_A:  r.rd = ddra;
          OFS_PORT_B: r.rd = pb;
          OFS_DDR_B:  r.rd = ddrb;
          OFS_FLAG: begin
            r.rd = tmr_flag ? BIT_7 : 8'h00;
            tmr_flag = 1'b0;
          end
          default: ;
        endcase
      end
      KIND_RIOT_WRITE: begin
        case (ofs)
          OFS_PORT_A: pa = (pa & ~ddra) | (dat & ddra);
          OFS_DDR_A:  ddra = dat;
          OFS_PORT_B: pb = dat;
          OFS_DDR_B:  ddrb = dat;
          OFS_TIMER: begin
            tmr_cnt = dat >> 1;
            tmr_run = 1'b1;
          end
          default: ;
        endcase
      end
      KIND_TICK: begin
        if (tmr_run) begin
          tmr_cnt = tmr_cnt - 8'd1;
          if (tmr_cnt == 8'd0) begin
            tmr_run  = 1'b0;
            tmr_flag = 1'b1;
            r.irq    = 1'b1;
          end
        end
      end
      KIND_POP: begin
        r.rd = cmd_mem[rd_ptr];
        if (cmd_cnt != 0) begin
          cmd_cnt = cmd_cnt - 1'b1;
          rd_ptr  = slot_after(rd_ptr);
        end
      end
      KIND_RESPOND: begin
        resp_byte = dat;
        pa        = pa | BIT_6;
      end
      KIND_MAIN_READ: begin
        pa   = pa & CLR_BIT_6;
        r.rd = resp_byte;
      end
      KIND_READY_READ: begin
        r.rd = (pa & BIT_6) | ((cmd_cnt >= FIFO_DEPTH) ? BIT_7 : 8'h00);
      end
      KIND_PUSH: begin
        if (cmd_cnt >= FIFO_DEPTH) begin
          cmd_cnt             = CNT_W'(1);
          cmd_mem[rd_ptr]     = dat;
          cmd_written[rd_ptr] = 1'b1;
          wr_ptr              = slot_after(rd_ptr);
        end else begin
          cmd_mem[wr_ptr]     = dat;
          cmd_written[wr_ptr] = 1'b1;
          wr_ptr              = slot_after(wr_ptr);
          cmd_cnt             = cmd_cnt + 1'b1;
        end
      end
      KIND_RESET: begin
        resp_byte = '0;
        rd_ptr    = '0;
        wr_ptr    = '0;
        cmd_cnt   = '0;
        pa        = pa & CLR_BITS_76;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] pick_offset();
    case ($urandom_range(0, 7))
      0: return OFS_PORT_A;
      1: return OFS_DDR_A;
      2: return OFS_PORT_B;
      3: return OFS_DDR_B;
      4: return OFS_FLAG;
      5: return OFS_TIMER;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [3:0] kind, input logic [4:0] ofs,
                              input logic [7:0] dat, input bit typed,
                              input reply_t typed_reply);
    reply_t want;
    want = mailbox_predict(kind, ofs, dat);
    if (typed) want = typed_reply;
    if (!send_calm) begin
      while ($urandom_range(0, 99) < 10) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {3'b000, dat, ofs};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_replies.push_back(want);
    if (kind <= KIND_RESET) requests_sent++;
    @(negedge clk);
  endtask

  // never pop a slot that was never filled; push instead
  task automatic rand_request(input logic [3:0] kind, input logic [4:0] ofs,
                              input logic [7:0] dat);
    logic [3:0] k;
    k = kind;
    if (k == KIND_POP && !cmd_written[rd_ptr]) k = KIND_PUSH;
    send_request(k, ofs, dat, 1'b0, '0);
  endtask

  task automatic random_phase();
    int         sel;
    int         n;
    int         ticks;
    logic [7:0] load;
    while (requests_sent < RANDOM_REQUESTS) begin
      send_calm = (requests_sent >= 400 && requests_sent < 700);
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        n = $urandom_range(1, FIFO_DEPTH + 2);
        repeat (n) begin
          rand_request(KIND_PUSH, 5'($urandom), 8'($urandom));
          if ($urandom_range(0, 3) == 0) rand_request(KIND_READY_READ, 5'($urandom), '0);
        end
        rand_request(KIND_RIOT_READ, OFS_PORT_A, 8'($urandom));
        n = $urandom_range(0, FIFO_DEPTH + 2);
        repeat (n) rand_request(KIND_POP, 5'($urandom), 8'($urandom));
      end else if (sel < 40) begin
        if (!wrap_done || $urandom_range(0, 29) == 0) begin
          load      = 8'($urandom_range(0, 1));
          wrap_done = 1'b1;
        end else begin
          load = 8'($urandom_range(2, 40));
        end
        rand_request(KIND_RIOT_WRITE, OFS_TIMER, load);
        ticks = (tmr_cnt == 0) ? 256 : int'(tmr_cnt);
        ticks = ticks + $urandom_range(0, 3) - $urandom_range(0, 1);
        repeat (ticks) begin
          rand_request(KIND_TICK, 5'($urandom), 8'($urandom));
          if ($urandom_range(0, 31) == 0) rand_request(KIND_RIOT_READ, OFS_FLAG, '0);
        end
        rand_request(KIND_RIOT_READ, OFS_FLAG, 8'($urandom));
      end else if (sel < 55) begin
        rand_request(KIND_RESPOND, 5'($urandom), 8'($urandom));
        rand_request(KIND_READY_READ, 5'($urandom), 8'($urandom));
        rand_request(KIND_MAIN_READ, 5'($urandom), 8'($urandom));
        rand_request(KIND_READY_READ, 5'($urandom), 8'($urandom));
      end else if (sel < 70) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          rand_request(KIND_RIOT_WRITE, pick_offset(), 8'($urandom));
          rand_request(KIND_RIOT_READ, pick_offset(), 8'($urandom));
        end
      end else if (sel < 75) begin
        rand_request(KIND_RESET, 5'($urandom), 8'($urandom));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) rand_request(4'($urandom_range(0, 15)), 5'($urandom), 8'($urandom));
      end
    end
    send_calm = 1'b0;
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i])
      send_request(dir_rows[i].kind, dir_rows[i].ofs, dir_rows[i].dat,
                   dir_rows[i].typed, dir_rows[i].reply);
    requests_sent = 0;
    random_phase();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hold off once long enough to back the block up, then a calm stretch
  initial begin
    int cyc;
    cyc = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
        m_tready <= 1'b0;
      end else if (cyc >= CALM_START && cyc < CALM_START + CALM_CYCLES) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 10);
      end
      cyc++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, got %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (m_tdata[7:0] !== want.rd) begin
          $display("%0t: read_data expected %h got %h", $time, want.rd, m_tdata[7:0]);
          mismatches++;
        end
        if (m_tdata[8] !== want.irq) begin
          $display("%0t: irq expected %b got %b", $time, want.irq, m_tdata[8]);
          mismatches++;
        end
        if (m_tdata[15:9] !== 7'd0) begin
          $display("%0t: pad bits expected 0 got %h", $time, m_tdata[15:9]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule
